// ===== rtl/kdop_pkg.sv =====
`default_nettype none

package kdop_pkg;

   // number of slab axes: x, y, z, x+y, x+z, y+z, x-y, x-z, y-z
   localparam int NUM_AXES = 9;
   localparam int AXIS_W   = 4;
   localparam int CODE_W   = 3;
   localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

   // request codes
   typedef enum logic [CODE_W-1:0] {
      REQ_ADD     = 3'd0,
      REQ_CLEAR   = 3'd1,
      REQ_TEST    = 3'd2,
      REQ_ENLARGE = 3'd3,
      REQ_READ    = 3'd4
   } req_code_type;

   // per-lane update controls
   typedef struct packed {
      logic load;
      logic widen;
      logic enlarge;
   } lane_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/kdop_ifs.sv =====
`default_nettype none

// request channel
interface kdop_req_if #(
   parameter int COORD_WIDTH = 32
);
   import kdop_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [CODE_W-1:0]             req_type;
   logic signed [COORD_WIDTH-1:0] coord_x;
   logic signed [COORD_WIDTH-1:0] coord_y;
   logic signed [COORD_WIDTH-1:0] coord_z;
   logic [COORD_WIDTH-2:0]        margin;

   modport source (output valid, req_type, coord_x, coord_y, coord_z, margin,
                   input ready);
   modport sink (input valid, req_type, coord_x, coord_y, coord_z, margin,
                 output ready);
endinterface

// result channel
interface kdop_rsp_if #(
   parameter int COORD_WIDTH = 32
);
   import kdop_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [AXIS_W-1:0]             axis;
   logic signed [COORD_WIDTH+1:0] low_bound;
   logic signed [COORD_WIDTH+1:0] high_bound;
   logic                          is_empty;
   logic                          inside_res;
   logic                          last;

   modport source (output valid, axis, low_bound, high_bound, is_empty, inside_res,
                   last, input ready);
   modport sink (input valid, axis, low_bound, high_bound, is_empty, inside_res,
                 last, output ready);
endinterface

`default_nettype wire

// ===== rtl/kdop18_bounds_builder.sv =====
// a test or read request is held in the request register, then loads its first result into
//   the result register; add, clear and enlarge take effect as they leave the request register
// throughput: one request per cycle while the result side keeps up; a read holds the execute
//   stage until all nine axes are out, one result per cycle while results are taken, set by the single result register
// reset: synchronous, active high; clears the pipeline and marks the polytope empty
`default_nettype none

module kdop18_bounds_builder #(
   parameter int COORD_WIDTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   kdop_req_if.sink    req_ch,
   kdop_rsp_if.source  rsp_ch
);
   import kdop_pkg::*;

   localparam int BOUND_W  = COORD_WIDTH + 2;
   localparam int MARGIN_W = COORD_WIDTH - 1;

   // request register
   logic                          s1_valid_ff, s1_valid_in;
   logic [CODE_W-1:0]             s1_code_ff;
   logic signed [COORD_WIDTH-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic [MARGIN_W-1:0]           s1_margin_ff;

   // state and readout control
   logic              empty_ff, empty_in;
   logic [AXIS_W-1:0] rd_idx_ff, rd_idx_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [AXIS_W-1:0]         rsp_axis_ff, rsp_axis_in;
   logic signed [BOUND_W-1:0] rsp_low_ff, rsp_low_in;
   logic signed [BOUND_W-1:0] rsp_high_ff, rsp_high_in;
   logic                      rsp_empty_ff, rsp_empty_in;
   logic                      rsp_inside_ff, rsp_inside_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic req_fire, out_free, needs_out, exe_fire, s1_done;
   logic is_add, is_clear, is_test, is_enlarge, is_read;
   lane_ctl_type lane_ctl;

   logic signed [BOUND_W-1:0] ext_x, ext_y, ext_z;
   logic signed [BOUND_W-1:0] axis_val  [NUM_AXES];
   logic signed [BOUND_W-1:0] lane_low  [NUM_AXES];
   logic signed [BOUND_W-1:0] lane_high [NUM_AXES];
   logic [NUM_AXES-1:0]       lane_in;
   logic                      inside_now;

   // decode the held request
   always_comb begin
      is_add     = 1'b0;
      is_clear   = 1'b0;
      is_test    = 1'b0;
      is_enlarge = 1'b0;
      is_read    = 1'b0;
      case (s1_code_ff)
         REQ_ADD:     is_add     = 1'b1;
         REQ_CLEAR:   is_clear   = 1'b1;
         REQ_TEST:    is_test    = 1'b1;
         REQ_ENLARGE: is_enlarge = 1'b1;
         REQ_READ:    is_read    = 1'b1;
         default:     is_add     = 1'b0;
      endcase
   end

   // flow control
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign needs_out = is_test || is_read;
   assign exe_fire  = s1_valid_ff && (!needs_out || out_free);
   assign s1_done   = exe_fire && (!is_read || (rd_idx_ff == LAST_AXIS));
   assign req_ch.ready = !s1_valid_ff || s1_done;
   assign req_fire  = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_code_ff   <= req_ch.req_type;
         s1_x_ff      <= req_ch.coord_x;
         s1_y_ff      <= req_ch.coord_y;
         s1_z_ff      <= req_ch.coord_z;
         s1_margin_ff <= req_ch.margin;
      end
   end

   // projections of the point onto the nine axes
   always_comb begin
      ext_x = {{2{s1_x_ff[COORD_WIDTH-1]}}, s1_x_ff};
      ext_y = {{2{s1_y_ff[COORD_WIDTH-1]}}, s1_y_ff};
      ext_z = {{2{s1_z_ff[COORD_WIDTH-1]}}, s1_z_ff};
      axis_val[0] = ext_x;
      axis_val[1] = ext_y;
      axis_val[2] = ext_z;
      axis_val[3] = ext_x + ext_y;
      axis_val[4] = ext_x + ext_z;
      axis_val[5] = ext_y + ext_z;
      axis_val[6] = ext_x - ext_y;
      axis_val[7] = ext_x - ext_z;
      axis_val[8] = ext_y - ext_z;
   end

   // lane controls
   always_comb begin
      lane_ctl.load    = exe_fire && is_add && empty_ff;
      lane_ctl.widen   = exe_fire && is_add && !empty_ff;
      lane_ctl.enlarge = exe_fire && is_enlarge && !empty_ff;
   end

   // one bounds lane per axis
   for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
      kdop_axis_lane #(
         .BOUND_W (BOUND_W)
      ) u_lane (
         .clock      (clock),
         .ctl        (lane_ctl),
         .axis_val   (axis_val[g]),
         .margin     (s1_margin_ff),
         .low_bound  (lane_low[g]),
         .high_bound (lane_high[g]),
         .in_slab    (lane_in[g])
      );
   end

   assign inside_now = !empty_ff && (&lane_in);

   // empty flag and readout index
   always_comb begin
      empty_in  = empty_ff;
      rd_idx_in = rd_idx_ff;
      if (exe_fire && is_add) begin
         empty_in = 1'b0;
      end else if (exe_fire && is_clear) begin
         empty_in = 1'b1;
      end
      if (exe_fire && is_read) begin
         if (rd_idx_ff == LAST_AXIS) begin
            rd_idx_in = '0;
         end else begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff  <= 1'b1;
         rd_idx_ff <= '0;
      end else begin
         empty_ff  <= empty_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_axis_in   = rsp_axis_ff;
      rsp_low_in    = rsp_low_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_last_in   = rsp_last_ff;
      if (exe_fire && is_test) begin
         rsp_valid_in  = 1'b1;
         rsp_axis_in   = '0;
         rsp_low_in    = '0;
         rsp_high_in   = '0;
         rsp_empty_in  = empty_ff;
         rsp_inside_in = inside_now;
         rsp_last_in   = 1'b1;
      end else if (exe_fire && is_read) begin
         rsp_valid_in  = 1'b1;
         rsp_axis_in   = rd_idx_ff;
         rsp_low_in    = empty_ff ? '0 : lane_low[rd_idx_ff];
         rsp_high_in   = empty_ff ? '0 : lane_high[rd_idx_ff];
         rsp_empty_in  = empty_ff;
         rsp_inside_in = 1'b0;
         rsp_last_in   = (rd_idx_ff == LAST_AXIS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_axis_ff   <= rsp_axis_in;
      rsp_low_ff    <= rsp_low_in;
      rsp_high_ff   <= rsp_high_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.axis       = rsp_axis_ff;
   assign rsp_ch.low_bound  = rsp_low_ff;
   assign rsp_ch.high_bound = rsp_high_ff;
   assign rsp_ch.is_empty   = rsp_empty_ff;
   assign rsp_ch.inside_res = rsp_inside_ff;
   assign rsp_ch.last       = rsp_last_ff;

`ifndef SYNTHESIS
   // a readout in progress always has a read request held
   a_rd_idx_held: assert property (@(posedge clock) disable iff (reset)
      (rd_idx_ff != '0) |-> (s1_valid_ff && is_read))
      else $error("readout index advanced without a held read request");

   // a clear leaves the polytope empty
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (exe_fire && is_clear) |=> empty_ff)
      else $error("clear did not empty the polytope");

   // a point found inside implies a non-empty polytope
   a_inside_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_inside_ff) |-> !rsp_empty_ff)
      else $error("inside result reported on an empty polytope");

   // last marks the final axis of a readout or a test result
   a_last_axis: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_axis_ff != LAST_AXIS))
      else $error("final axis emitted without last");
`endif

endmodule

`default_nettype wire

// ===== rtl/kdop_axis_lane.sv =====
`default_nettype none

module kdop_axis_lane #(
   parameter int BOUND_W = 34
) (
   input  wire                       clock,
   input  kdop_pkg::lane_ctl_type    ctl,
   input  wire logic signed [BOUND_W-1:0] axis_val,
   input  wire logic [BOUND_W-4:0]   margin,
   output logic signed [BOUND_W-1:0] low_bound,
   output logic signed [BOUND_W-1:0] high_bound,
   output logic                      in_slab
);
   import kdop_pkg::*;

   localparam logic signed [BOUND_W-1:0] BOUND_MAX = {1'b0, {(BOUND_W-1){1'b1}}};
   localparam logic signed [BOUND_W-1:0] BOUND_MIN = {1'b1, {(BOUND_W-1){1'b0}}};

   logic signed [BOUND_W-1:0] low_ff, low_in;
   logic signed [BOUND_W-1:0] high_ff, high_in;
   logic signed [BOUND_W:0]   low_ext, high_ext, margin_ext;
   logic signed [BOUND_W:0]   low_grow, high_grow;
   logic signed [BOUND_W-1:0] low_sat, high_sat;

   // enlarge one bit wider, then clamp to the bound range
   always_comb begin
      low_ext    = {low_ff[BOUND_W-1], low_ff};
      high_ext   = {high_ff[BOUND_W-1], high_ff};
      margin_ext = {4'b0000, margin};
      low_grow   = low_ext - margin_ext;
      high_grow  = high_ext + margin_ext;
      if (low_grow[BOUND_W] != low_grow[BOUND_W-1]) begin
         low_sat = BOUND_MIN;
      end else begin
         low_sat = low_grow[BOUND_W-1:0];
      end
      if (high_grow[BOUND_W] != high_grow[BOUND_W-1]) begin
         high_sat = BOUND_MAX;
      end else begin
         high_sat = high_grow[BOUND_W-1:0];
      end
   end

   // next bounds: load on first point, min/max on later points, saturated margin on enlarge
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (ctl.load) begin
         low_in  = axis_val;
         high_in = axis_val;
      end else if (ctl.widen) begin
         if (axis_val < low_ff) begin
            low_in = axis_val;
         end
         if (axis_val > high_ff) begin
            high_in = axis_val;
         end
      end else if (ctl.enlarge) begin
         low_in  = low_sat;
         high_in = high_sat;
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      high_ff <= high_in;
   end

   // slab test, inclusive at both ends
   assign in_slab    = (axis_val >= low_ff) && (axis_val <= high_ff);
   assign low_bound  = low_ff;
   assign high_bound = high_ff;

endmodule

`default_nettype wire

// ===== tb/sv/kdop18_bounds_checker.sv =====
module kdop18_bounds_checker
   import kdop_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [CODE_W-1:0]             req_type,
   input  logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [COORD_WIDTH-1:0] req_coord_y,
   input  logic signed [COORD_WIDTH-1:0] req_coord_z,
   input  logic [COORD_WIDTH-2:0]        req_margin,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [AXIS_W-1:0]             rsp_axis,
   input  logic signed [COORD_WIDTH+1:0] rsp_low_bound,
   input  logic signed [COORD_WIDTH+1:0] rsp_high_bound,
   input  logic                          rsp_is_empty,
   input  logic                          rsp_inside_res,
   input  logic                          rsp_last,
   output int                            failures,
   output int                            pending,
   output int                            inside_hits,
   output int                            results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BW = COORD_WIDTH + 2;

   typedef logic signed [COORD_WIDTH-1:0] coord_t;
   typedef logic signed [BW-1:0]          bound_t;
   typedef logic signed [BW:0]            wide_t;

   // saturation limits of a bound, held one bit wider
   localparam wide_t BOUND_HI = wide_t'({2'b00, {(BW-1){1'b1}}});
   localparam wide_t BOUND_LO = wide_t'({2'b11, {(BW-1){1'b0}}});

   typedef struct {
      logic [AXIS_W-1:0] axis;
      bound_t            low_b;
      bound_t            high_b;
      logic              empty;
      logic              in_slabs;
      logic              last;
   } readout_t;

   // predicted polytope
   bound_t   slab_lo [NUM_AXES];
   bound_t   slab_hi [NUM_AXES];
   logic     poly_empty;
   readout_t owed_readouts [$];

   // projection of a point onto one of the nine axes
   function automatic bound_t slab_of(input int k, input coord_t x, input coord_t y,
                                      input coord_t z);
      bound_t sx, sy, sz;
      sx = x;
      sy = y;
      sz = z;
      case (k)
         0: return sx;
         1: return sy;
         2: return sz;
         3: return sx + sy;
         4: return sx + sz;
         5: return sy + sz;
         6: return sx - sy;
         7: return sx - sz;
         default: return sy - sz;
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input longint want, input longint got);
      $display("[%0t] mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
      failures++;
   endtask

   // compare one accepted result with the oldest prediction
   task automatic check_readout();
      readout_t want;
      if (owed_readouts.size() == 0) begin
         flag_mismatch("unrequested result (axis shown)", -1, rsp_axis);
         return;
      end
      want = owed_readouts.pop_front();
      results_seen++;
      if (rsp_axis !== want.axis)             flag_mismatch("axis", want.axis, rsp_axis);
      if (rsp_low_bound !== want.low_b)       flag_mismatch("low_bound", want.low_b,
                                                            rsp_low_bound);
      if (rsp_high_bound !== want.high_b)     flag_mismatch("high_bound", want.high_b,
                                                            rsp_high_bound);
      if (rsp_is_empty !== want.empty)        flag_mismatch("is_empty", want.empty,
                                                            rsp_is_empty);
      if (rsp_inside_res !== want.in_slabs)   flag_mismatch("inside_res", want.in_slabs,
                                                            rsp_inside_res);
      if (rsp_last !== want.last)             flag_mismatch("last", want.last, rsp_last);
   endtask

   // apply one accepted request to the predicted polytope
   task automatic update_polytope();
      bound_t   v;
      wide_t    w;
      wide_t    grow;
      logic     hit;
      readout_t r;
      case (req_type)
         REQ_ADD: begin
            for (int k = 0; k < NUM_AXES; k++) begin
               v = slab_of(k, req_coord_x, req_coord_y, req_coord_z);
               if (poly_empty || v < slab_lo[k]) slab_lo[k] = v;
               if (poly_empty || v > slab_hi[k]) slab_hi[k] = v;
            end
            poly_empty = 1'b0;
         end
         REQ_CLEAR: poly_empty = 1'b1;
         REQ_TEST: begin
            hit = !poly_empty;
            for (int k = 0; k < NUM_AXES; k++) begin
               v = slab_of(k, req_coord_x, req_coord_y, req_coord_z);
               if (v < slab_lo[k] || v > slab_hi[k]) hit = 1'b0;
            end
            r.axis     = '0;
            r.low_b    = '0;
            r.high_b   = '0;
            r.empty    = poly_empty;
            r.in_slabs = hit;
            r.last     = 1'b1;
            owed_readouts.push_back(r);
            if (hit) inside_hits++;
         end
         REQ_ENLARGE: begin
            // ignored while empty; otherwise push every bound outward and clamp
            if (!poly_empty) begin
               grow = req_margin;
               for (int k = 0; k < NUM_AXES; k++) begin
                  w = slab_lo[k];
                  w = w - grow;
                  if (w < BOUND_LO) w = BOUND_LO;
                  slab_lo[k] = w[BW-1:0];
                  w = slab_hi[k];
                  w = w + grow;
                  if (w > BOUND_HI) w = BOUND_HI;
                  slab_hi[k] = w[BW-1:0];
               end
            end
         end
         REQ_READ: begin
            for (int k = 0; k < NUM_AXES; k++) begin
               r.axis     = AXIS_W'(k);
               r.low_b    = poly_empty ? bound_t'(0) : slab_lo[k];
               r.high_b   = poly_empty ? bound_t'(0) : slab_hi[k];
               r.empty    = poly_empty;
               r.in_slabs = 1'b0;
               r.last     = (k == NUM_AXES - 1);
               owed_readouts.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   // results first: nothing accepted at this edge can answer at the same edge
   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            slab_lo[k] = '0;
            slab_hi[k] = '0;
         end
         poly_empty = 1'b1;
         owed_readouts.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_readout();
         if (req_valid && req_ready) update_polytope();
      end
      pending <= owed_readouts.size();
   end

endmodule

// ===== tb/sv/tb_kdop18_bounds_builder.sv =====
module tb_kdop18_bounds_builder;
   timeunit 1ns;
   timeprecision 1ps;

   import kdop_pkg::*;

   localparam int CW           = 32;
   localparam int RANDOM_ITEMS = 380;
   localparam int RUN_LIMIT    = 600000;

   typedef logic signed [CW-1:0] coord_t;
   typedef logic [CW-2:0]        margin_t;

   localparam coord_t  COORD_MAX  = {1'b0, {(CW-1){1'b1}}};
   localparam coord_t  COORD_MIN  = {1'b1, {(CW-1){1'b0}}};
   localparam coord_t  ONE_Q16    = coord_t'(1) <<< 16;
   localparam margin_t MARGIN_MAX = '1;
   // codes above read have no meaning to the block
   localparam logic [CODE_W-1:0] REQ_SPARE_FIRST = CODE_W'(REQ_READ) + CODE_W'(1);

   logic clock;
   logic reset;

   kdop_req_if #(.COORD_WIDTH(CW)) req_ch ();
   kdop_rsp_if #(.COORD_WIDTH(CW)) rsp_ch ();

   int          failures;
   int          pending;
   int          inside_hits;
   int          results_seen;
   int unsigned cycle_count;
   int          stall_left;
   int          rsp_gap;
   logic        rsp_calm;
   logic        req_calm;
   int          sent_by_code [8];

   // up to sixteen most recent points added since the last clear, reused as probe points
   coord_t pts_x [16];
   coord_t pts_y [16];
   coord_t pts_z [16];
   int     pt_count;

   kdop18_bounds_builder #(.COORD_WIDTH(CW)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   kdop18_bounds_checker #(.COORD_WIDTH(CW)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_type       (req_ch.req_type),
      .req_coord_x    (req_ch.coord_x),
      .req_coord_y    (req_ch.coord_y),
      .req_coord_z    (req_ch.coord_z),
      .req_margin     (req_ch.margin),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_axis       (rsp_ch.axis),
      .rsp_low_bound  (rsp_ch.low_bound),
      .rsp_high_bound (rsp_ch.high_bound),
      .rsp_is_empty   (rsp_ch.is_empty),
      .rsp_inside_res (rsp_ch.inside_res),
      .rsp_last       (rsp_ch.last),
      .failures       (failures),
      .pending        (pending),
      .inside_hits    (inside_hits),
      .results_seen   (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic coord_t pick_coord();
      int     roll;
      coord_t c;
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         c = $urandom_range(0, 4095);
         c = (c - 2048) <<< 10;
      end else if (roll < 80) begin
         c = CW'({$urandom, $urandom});
      end else if (roll < 90) begin
         case ($urandom_range(0, 3))
            0:       c = COORD_MAX;
            1:       c = COORD_MIN;
            2:       c = '0;
            default: c = '1;
         endcase
      end else begin
         c = $urandom_range(0, 1) ? COORD_MAX - CW'($urandom_range(0, 255))
                                  : COORD_MIN + CW'($urandom_range(0, 255));
      end
      return c;
   endfunction

   function automatic margin_t pick_margin();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return margin_t'($urandom_range(0, 1 << 16));
      if (roll < 85) return margin_t'({$urandom, $urandom});
      if (roll < 95) return MARGIN_MAX;
      return '0;
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (reset || rsp_calm) begin
         rsp_ch.ready <= 1'b1;
         stall_left   <= 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         rsp_gap = pick_gap();
         rsp_ch.ready <= (rsp_gap == 0);
         stall_left   <= (rsp_gap > 0) ? rsp_gap - 1 : 0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still awaited", cycle_count, pending);
         $display("tb_kdop18_bounds_builder failed");
         $finish;
      end
   end

   // hold one request until accepted, then maybe idle
   task automatic send_req(input logic [CODE_W-1:0] code, input coord_t x, input coord_t y,
                           input coord_t z, input margin_t m);
      int g;
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= code;
      req_ch.coord_x  <= x;
      req_ch.coord_y  <= y;
      req_ch.coord_z  <= z;
      req_ch.margin   <= m;
      do @(posedge clock); while (!req_ch.ready);
      sent_by_code[code]++;
      g = req_calm ? 0 : pick_gap();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic add_point(input coord_t x, input coord_t y, input coord_t z);
      send_req(REQ_ADD, x, y, z, pick_margin());
      pts_x[pt_count % 16] = x;
      pts_y[pt_count % 16] = y;
      pts_z[pt_count % 16] = z;
      pt_count++;
   endtask

   task automatic clear_poly();
      send_req(REQ_CLEAR, pick_coord(), pick_coord(), pick_coord(), pick_margin());
      pt_count = 0;
   endtask

   // sender holds off until every awaited result is in
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      int     useful;
      int     roll;
      int     pick;
      coord_t px, py, pz;

      reset           = 1'b1;
      rsp_calm        = 1'b0;
      req_calm        = 1'b0;
      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_ADD;
      req_ch.coord_x  = '0;
      req_ch.coord_y  = '0;
      req_ch.coord_z  = '0;
      req_ch.margin   = '0;
      rsp_ch.ready    = 1'b0;
      cycle_count     = 0;
      stall_left      = 0;
      pt_count        = 0;
      useful          = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty polytope behavior
      send_req(REQ_TEST, '0, '0, '0, '0);
      send_req(REQ_READ, COORD_MAX, COORD_MIN, '1, MARGIN_MAX);
      send_req(REQ_ENLARGE, '0, '0, '0, MARGIN_MAX);
      for (int c = REQ_SPARE_FIRST; c < 8; c++)
         send_req(CODE_W'(c), COORD_MAX, COORD_MAX, COORD_MAX, MARGIN_MAX);

      // directed: extreme corners, then saturation of every bound
      add_point(COORD_MAX, COORD_MAX, COORD_MAX);
      add_point(COORD_MIN, COORD_MIN, COORD_MIN);
      send_req(REQ_READ, '0, '0, '0, '0);
      send_req(REQ_TEST, '0, '0, '0, '0);
      send_req(REQ_TEST, COORD_MAX, COORD_MIN, '0, '0);
      repeat (5) send_req(REQ_ENLARGE, '0, '0, '0, MARGIN_MAX);
      send_req(REQ_READ, '0, '0, '0, '0);

      // directed: clear, single point, edges of the slabs
      clear_poly();
      send_req(REQ_TEST, '0, '0, '0, '0);
      add_point(ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16);
      send_req(REQ_TEST, ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16, '0);
      send_req(REQ_TEST, ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16 + 1, '0);
      send_req(REQ_ENLARGE, '0, '0, '0, '0);
      send_req(REQ_READ, '0, '0, '0, '0);
      drain();

      // random mix; spare codes and enlarges with no points added do not count toward the total
      while (useful < RANDOM_ITEMS) begin
         if (useful % 60 == 0) begin
            rsp_calm <= ($urandom_range(0, 2) == 0);
            req_calm =  ($urandom_range(0, 2) == 0);
         end
         if (useful == RANDOM_ITEMS / 2) drain();
         roll = $urandom_range(0, 99);
         useful++;
         if (roll < 34) begin
            add_point(pick_coord(), pick_coord(), pick_coord());
         end else if (roll < 40 && pt_count > 0) begin
            // widen slightly around a known point
            pick = $urandom_range(0, (pt_count > 16 ? 16 : pt_count) - 1);
            add_point(pts_x[pick] + coord_t'($urandom_range(0, 64)) - 32,
                      pts_y[pick] + coord_t'($urandom_range(0, 64)) - 32,
                      pts_z[pick] + coord_t'($urandom_range(0, 64)) - 32);
         end else if (roll < 70) begin
            // probe at a known point, near it, or anywhere
            pick = (pt_count > 0) ? $urandom_range(0, (pt_count > 16 ? 16 : pt_count) - 1) : 0;
            px = pick_coord();
            py = pick_coord();
            pz = pick_coord();
            if (pt_count > 0 && $urandom_range(0, 3) != 0) begin
               px = pts_x[pick];
               py = pts_y[pick];
               pz = pts_z[pick];
               if ($urandom_range(0, 2) == 0) begin
                  px = px + coord_t'($urandom_range(0, 2)) - 1;
                  pz = pz + coord_t'($urandom_range(0, 2)) - 1;
               end
            end
            send_req(REQ_TEST, px, py, pz, pick_margin());
         end else if (roll < 78) begin
            send_req(REQ_READ, pick_coord(), pick_coord(), pick_coord(), pick_margin());
         end else if (roll < 88) begin
            if (pt_count == 0) useful--;
            send_req(REQ_ENLARGE, pick_coord(), pick_coord(), pick_coord(), pick_margin());
         end else if (roll < 95) begin
            clear_poly();
         end else begin
            useful--;
            send_req(CODE_W'($urandom_range(REQ_SPARE_FIRST, 7)), pick_coord(), pick_coord(),
                     pick_coord(), pick_margin());
         end
      end

      // wind down
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (12) @(posedge clock);

      $display("sent %0d adds, %0d clears, %0d tests, %0d enlarges, %0d reads, %0d spare codes",
               sent_by_code[REQ_ADD], sent_by_code[REQ_CLEAR], sent_by_code[REQ_TEST],
               sent_by_code[REQ_ENLARGE], sent_by_code[REQ_READ],
               sent_by_code[5] + sent_by_code[6] + sent_by_code[7]);
      $display("checked %0d results, %0d tests found the point inside, %0d mismatches",
               results_seen, inside_hits, failures);
      if (failures == 0) begin
         $display("tb_kdop18_bounds_builder passed");
      end else begin
         $display("tb_kdop18_bounds_builder failed");
      end
      $finish;
   end

endmodule
